>>> rtl/bpc_pkg.sv
// Package for the button press classifier.
// Holds the sizing constants, event and register codes, and lane structs.
// No dependencies.
package bpc_pkg;

  localparam int unsigned BUTTON_COUNT = 3;
  localparam int unsigned TIME_WIDTH   = 16;
  localparam int unsigned THR_WIDTH    = 16;
  localparam int unsigned TICK_WIDTH   = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned EVT_WIDTH    = 2 * BUTTON_COUNT;
  localparam int unsigned SUM_W        = TIME_WIDTH + 1;
  localparam int unsigned CMP_W        = (TIME_WIDTH > THR_WIDTH) ? TIME_WIDTH : THR_WIDTH;

  // Released ticks needed after reset before a press counts
  localparam logic [1:0] GUARD_TICKS = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_PERIOD     = 3'd0,
    REG_SHORT_THRESHOLD = 3'd1,
    REG_LONG_THRESHOLD  = 3'd2,
    REG_GUARD_BAND      = 3'd3,
    REG_ACTIVE_LEVELS   = 3'd4
  } cfg_reg_e;

  // Timing settings shared by every lane
  typedef struct packed {
    logic [TICK_WIDTH-1:0] tick_period;
    logic [THR_WIDTH-1:0]  short_threshold;
    logic [THR_WIDTH-1:0]  long_threshold;
    logic [THR_WIDTH-1:0]  guard_band;
  } lane_cfg_t;

  // What one lane reports for the current tick
  typedef struct packed {
    event_e ev;
    logic   held;
  } lane_res_t;

endpackage

>>> rtl/bpc_lane.sv
// One button lane: held time, release guard, held and long-reported state.
// Classifies the tick into none, short or long. Depends on bpc_pkg.
module bpc_lane import bpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      pin_level_i,
  input  logic      active_level_i,
  input  lane_cfg_t cfg_i,
  output lane_res_t res_o
);

  logic [TIME_WIDTH-1:0] time_q, time_d, time_upd;
  logic [1:0]            guard_q, guard_d;
  logic                  held_q, held_d;
  logic                  long_rep_q, long_rep_d;

  logic                  pressed;
  logic                  guard_ok;
  logic [SUM_W-1:0]      sum;
  logic [CMP_W-1:0]      time_cmp;
  logic [THR_WIDTH-1:0]  short_limit;
  event_e                ev;

  assign pressed  = (pin_level_i == active_level_i);
  assign guard_ok = (guard_q >= GUARD_TICKS);

  // Saturating held-time increment
  assign sum      = SUM_W'(time_q) + SUM_W'(cfg_i.tick_period);
  assign time_upd = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

  // Count presses once the guard is met; count released ticks up to the guard
  always_comb begin
    held_d  = held_q;
    time_d  = time_q;
    guard_d = guard_q;
    if (pressed) begin
      if (guard_ok) begin
        time_d = time_upd;
        held_d = 1'b1;
      end
    end else begin
      held_d = 1'b0;
      if (!guard_ok) begin
        guard_d = guard_q + 2'd1;
      end
    end
  end

  assign time_cmp    = CMP_W'(time_d);
  assign short_limit = cfg_i.long_threshold - cfg_i.guard_band;

  // Classify: long once per hold, short on the release tick inside the window
  always_comb begin
    ev         = EV_NONE;
    long_rep_d = long_rep_q;
    if (held_d) begin
      if (time_cmp >= CMP_W'(cfg_i.long_threshold)) begin
        if (!long_rep_q) begin
          ev = EV_LONG;
        end
        long_rep_d = 1'b1;
      end
    end else begin
      if (held_q && (cfg_i.guard_band < cfg_i.long_threshold)) begin
        if ((time_cmp >= CMP_W'(cfg_i.short_threshold)) &&
            (time_cmp < CMP_W'(short_limit))) begin
          ev = EV_SHORT;
        end
      end
      long_rep_d = 1'b0;
    end
  end

  // Advance lane state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q     <= '0;
      guard_q    <= '0;
      held_q     <= 1'b0;
      long_rep_q <= 1'b0;
    end else if (step_i) begin
      time_q     <= held_d ? time_d : '0;
      guard_q    <= guard_d;
      held_q     <= held_d;
      long_rep_q <= long_rep_d;
    end
  end

  assign res_o.ev   = ev;
  assign res_o.held = held_d;

endmodule

>>> rtl/bpc_merge.sv
// Merging stage: packs the lane results into the output register.
// Holds the result while the receiver stalls. Depends on bpc_pkg.
module bpc_merge import bpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  lane_res_t               res_i [BUTTON_COUNT],
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [EVT_WIDTH-1:0]    events_o,
  output logic [BUTTON_COUNT-1:0] held_flags_o
);

  logic                    valid_q, valid_d;
  logic [EVT_WIDTH-1:0]    events_q, events_d;
  logic [BUTTON_COUNT-1:0] flags_q, flags_d;

  // Gather the per-lane codes and flags
  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      events_d[2*i +: 2] = res_i[i].ev;
      flags_d[i]         = res_i[i].held;
    end
  end

  // Keep the result until the transfer completes
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      events_q <= events_d;
      flags_q  <= flags_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign events_o     = events_q;
  assign held_flags_o = flags_q;

endmodule

>>> rtl/button_press_classifier.sv
// Top level of the button press classifier: configuration registers,
// one lane per button and the merging stage. Depends on bpc_pkg,
// bpc_lane and bpc_merge.
//
// Usage
//   Input channel: one transfer per scan tick, pin_levels_i holds the
//   sampled level of every button (bit i is button i).
//   Output channel: one result per tick, events_o has two bits per button
//   (none, short, long) and held_flags_o marks buttons counted as held.
//   Configuration: cfg_index_i selects tick_period, short_threshold,
//   long_threshold, guard_band or active_levels; cfg_ready_o is always high.
//   The result is registered in the cycle after the input transfer; a tick
//   is taken every cycle, limited only by the single output register.
//   When the receiver stalls, the result holds in the output register and
//   in_stall_o rises, so no further tick is taken until the register frees.
//   Reset clears all lane state and loads the default settings; each
//   button then needs two released ticks before its presses count.
module button_press_classifier import bpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [BUTTON_COUNT-1:0] pin_levels_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [EVT_WIDTH-1:0]    events_o,
  output logic [BUTTON_COUNT-1:0] held_flags_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  lane_cfg_t               cfg_q;
  logic [BUTTON_COUNT-1:0] active_q;
  lane_res_t               res [BUTTON_COUNT];
  logic                    step;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period     <= TICK_WIDTH'(10);
      cfg_q.short_threshold <= THR_WIDTH'(50);
      cfg_q.long_threshold  <= THR_WIDTH'(1000);
      cfg_q.guard_band      <= THR_WIDTH'(200);
      active_q              <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TICK_PERIOD:     cfg_q.tick_period     <= cfg_data_i[TICK_WIDTH-1:0];
        REG_SHORT_THRESHOLD: cfg_q.short_threshold <= cfg_data_i[THR_WIDTH-1:0];
        REG_LONG_THRESHOLD:  cfg_q.long_threshold  <= cfg_data_i[THR_WIDTH-1:0];
        REG_GUARD_BAND:      cfg_q.guard_band      <= cfg_data_i[THR_WIDTH-1:0];
        REG_ACTIVE_LEVELS:   active_q              <= cfg_data_i[BUTTON_COUNT-1:0];
        default: ;
      endcase
    end
  end

  // Stall only while the output register is full and not being drained
  assign in_stall_o = out_valid_o & out_stall_i;
  assign step       = in_valid_i & ~in_stall_o;

  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    bpc_lane u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .step_i         (step),
      .pin_level_i    (pin_levels_i[g]),
      .active_level_i (active_q[g]),
      .cfg_i          (cfg_q),
      .res_o          (res[g])
    );
  end

  bpc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .res_i        (res),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .events_o     (events_o),
    .held_flags_o (held_flags_o)
  );

endmodule

>>> rtl/bpc_checker.sv
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier.
module bpc_checker import bpc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [EVT_WIDTH-1:0]    events_o,
  input logic [BUTTON_COUNT-1:0] held_flags_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(events_o) &&
    $stable(held_flags_o))
    else $error("stalled result changed");

  // An input transfer yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick gave no result");

  // The input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_btn
    // Long press only while held, short press only on release, never code 3
    a_event_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |->
      ((events_o[2*g +: 2] == EV_NONE) ||
       ((events_o[2*g +: 2] == EV_LONG) && held_flags_o[g]) ||
       ((events_o[2*g +: 2] == EV_SHORT) && !held_flags_o[g])))
      else $error("event code disagrees with held flag");
  end

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);
